>>> rtl/core/mcht_pkg.sv
// mesh cell hash table: shared types, sizes and codes
// no dependencies; imported by every module of the core but mcht_ram
package mcht_pkg;

  // table geometry
  localparam int BUCKETS     = 1024;
  localparam int DEPTH       = 4;
  localparam int HANDLE_BITS = 16;
  localparam int BKT_W       = $clog2(BUCKETS);
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int SLOT_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BC_W        = 11;
  localparam int KEY_W       = 20;
  localparam int DIV_CNT_W   = $clog2(KEY_W);
  localparam int COUNT_W     = 13;
  localparam int MAX_LEVEL   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_LEVEL = 2'd3;

  // item classes set by the front end
  localparam logic [1:0] KIND_RUN = 2'd0;
  localparam logic [1:0] KIND_BAD = 2'd1;
  localparam logic [1:0] KIND_NOP = 2'd2;

  typedef struct packed {
    logic [8:0]             x;
    logic [8:0]             y;
    logic [2:0]             level;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  // one memory row holds a whole bucket
  typedef struct packed {
    logic [FILL_W-1:0]     fill;
    slot_t [DEPTH-1:0]     slots;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic [1:0]       opcode;
    logic [1:0]       kind;
    logic [BKT_W-1:0] bucket;
    slot_t            entry;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // sum of squared side lengths of all coarser levels
  function automatic logic [KEY_W-1:0] level_offset(input logic [2:0] level);
    logic [KEY_W-1:0] r;
    r = '0;
    unique case (level)
      3'd0: r = KEY_W'(0);
      3'd1: r = KEY_W'(1024);
      3'd2: r = KEY_W'(5120);
      3'd3: r = KEY_W'(21504);
      3'd4: r = KEY_W'(87040);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/mcht_ram.sv
// generic single write port ram with registered read
// no dependencies
module mcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/mcht_front.sv
// front end: takes commands, classifies them, hashes the key to a bucket
// uses mcht_pkg; bit-serial remainder by the configured bucket count
module mcht_front
  import mcht_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      opcode,
  input  logic [8:0]      cell_x,
  input  logic [8:0]      cell_y,
  input  logic [2:0]      cell_level,
  input  logic [15:0]     cell_handle,
  input  logic [BC_W-1:0] bucket_count,
  output logic            push,
  output item_t           push_item,
  input  logic            q_full
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  item_t                item;
  logic [KEY_W-1:0]     key;
  logic [BC_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [BC_W-1:0]      bc;
  logic [BC_W:0]        trial;
  logic [KEY_W-1:0]     key_init;

  // clamp the bucket count to 1..BUCKETS
  always_comb begin
    if (bucket_count == '0) begin
      bc = BC_W'(1);
    end else if (bucket_count > BC_W'(BUCKETS)) begin
      bc = BC_W'(BUCKETS);
    end else begin
      bc = bucket_count;
    end
  end

  // raw key, congruent to the hashed key before the final remainder
  assign key_init = KEY_W'(cell_x) + (KEY_W'(cell_y) << (5 + cell_level))
                  + level_offset(cell_level);

  // one restoring remainder step
  assign trial = {rem, key[KEY_W-1]};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_NONE || cell_level > 3'(MAX_LEVEL)) begin
            state_next = S_PUSH;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (cnt == DIV_CNT_W'(KEY_W - 1)) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!q_full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload and divider datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      item.opcode       <= opcode;
      item.entry.x      <= cell_x;
      item.entry.y      <= cell_y;
      item.entry.level  <= cell_level;
      item.entry.handle <= HANDLE_BITS'(cell_handle);
      item.bucket       <= '0;
      if (opcode == OP_NONE) begin
        item.kind <= KIND_NOP;
      end else if (cell_level > 3'(MAX_LEVEL)) begin
        item.kind <= KIND_BAD;
      end else begin
        item.kind <= KIND_RUN;
      end
      key <= key_init;
      rem <= '0;
      cnt <= '0;
    end else if (state == S_DIV) begin
      key <= {key[KEY_W-2:0], 1'b0};
      cnt <= cnt + DIV_CNT_W'(1);
      if (trial >= {1'b0, bc}) begin
        rem <= BC_W'(trial - {1'b0, bc});
      end else begin
        rem <= trial[BC_W-1:0];
      end
      if (cnt == DIV_CNT_W'(KEY_W - 1)) begin
        if (trial >= {1'b0, bc}) begin
          item.bucket <= BKT_W'(trial - {1'b0, bc});
        end else begin
          item.bucket <= trial[BKT_W-1:0];
        end
      end
    end
  end

  assign busy      = (state != S_IDLE);
  assign push      = (state == S_PUSH) && !q_full;
  assign push_item = item;

endmodule

>>> rtl/core/mcht_queue.sv
// short fifo between front end and back end
// uses mcht_pkg for the item type
module mcht_queue
  import mcht_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  assign head  = mem[rptr];
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

endmodule

>>> rtl/core/mcht_back.sv
// back end: bucket read-modify-write on the row memory, result and count
// uses mcht_pkg and mcht_ram; clears every bucket after reset
module mcht_back
  import mcht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  item_t              head,
  output logic               pop,
  output logic               clearing,
  output logic               done,
  output logic [1:0]         status,
  output logic               found,
  output logic [15:0]        found_handle,
  output logic [COUNT_W-1:0] entry_count
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]         state;
  logic [BKT_W-1:0]   clr;
  item_t              item;
  logic [ROW_W-1:0]   rdata;
  row_t               row;
  row_t               row_new;
  logic               we;
  logic [BKT_W-1:0]   waddr;
  logic [ROW_W-1:0]   wdata;
  logic               hit;
  logic [SLOT_W-1:0]  k;
  logic [1:0]         st;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] total_next;

  mcht_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(head.bucket),
    .rdata(rdata)
  );

  assign row = row_t'(rdata);

  // first match among the filled slots
  always_comb begin
    hit = 1'b0;
    k   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!hit && FILL_W'(i) < row.fill && row.slots[i].x == item.entry.x
          && row.slots[i].y == item.entry.y
          && row.slots[i].level == item.entry.level) begin
        hit = 1'b1;
        k   = SLOT_W'(i);
      end
    end
  end

  // bucket update and result status
  always_comb begin
    row_new    = row;
    st         = ST_OK;
    total_next = total;
    case (item.kind)
      KIND_BAD: st = ST_BAD_LEVEL;
      KIND_RUN: begin
        if (item.opcode == OP_INSERT) begin
          if (row.fill >= FILL_W'(DEPTH)) begin
            st = ST_FULL;
          end else begin
            row_new.slots[row.fill[SLOT_W-1:0]] = item.entry;
            row_new.fill = row.fill + FILL_W'(1);
            total_next   = total + COUNT_W'(1);
          end
        end else if (!hit) begin
          st = ST_NOT_FOUND;
        end else if (item.opcode == OP_REMOVE) begin
          for (int j = 0; j < DEPTH - 1; j++) begin
            if (SLOT_W'(j) >= k) begin
              row_new.slots[j] = row.slots[j + 1];
            end
          end
          row_new.fill = row.fill - FILL_W'(1);
          total_next   = total - COUNT_W'(1);
        end
      end
      default: st = ST_OK;
    endcase
  end

  // memory write: clearing sweep or bucket write-back
  always_comb begin
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr;
      wdata = '0;
    end else begin
      we    = (state == S_EXEC) && (total_next != total);
      waddr = item.bucket;
      wdata = ROW_W'(row_new);
    end
  end

  assign pop      = (state == S_IDLE) && !q_empty;
  assign clearing = (state == S_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + BKT_W'(1);
          if (clr == BKT_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          total <= total_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head;
    end
    if (state == S_EXEC) begin
      status <= st;
      if (item.kind == KIND_RUN && item.opcode != OP_INSERT && hit) begin
        found        <= 1'b1;
        found_handle <= 16'(row.slots[k].handle);
      end else begin
        found        <= 1'b0;
        found_handle <= '0;
      end
    end
  end

  assign entry_count = total;

endmodule

>>> rtl/core/mesh_cell_hash_table_core.sv
// mesh cell hash table top level: front end, queue, back end
// uses mcht_pkg, mcht_front, mcht_queue, mcht_back
//
// channel   direction  handshake              payload
// command   in         start & !busy          opcode cell_x cell_y cell_level cell_handle
// config    in         cfg_valid & cfg_ready  cfg_data (bucket count)
// result    out        done, one cycle        status found found_handle entry_count
//
// a hashed command runs 20 steps of the bit-serial remainder by the bucket count,
// then queue push, row read, write-back and the result register, and done strobes;
// the next command is taken once the front end has pushed the last into the queue.
// bad-level and opcode 3 commands skip the remainder and go straight to the push.
// after reset the back end sweeps all 1024 bucket rows while busy stays high;
// config writes are taken at any time.
// the result receiver cannot stall; a result shows for one cycle on done.
module mesh_cell_hash_table_core
  import mcht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [8:0]         cell_x,
  input  logic [8:0]         cell_y,
  input  logic [2:0]         cell_level,
  input  logic [15:0]        cell_handle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BC_W-1:0]    cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic               found,
  output logic [15:0]        found_handle,
  output logic [COUNT_W-1:0] entry_count
);

  logic [BC_W-1:0] bucket_count;
  logic            front_busy;
  logic            push;
  item_t           push_item;
  logic            pop;
  item_t           head;
  logic            q_full;
  logic            q_empty;
  logic            clearing;

  // bucket count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_W'(BUCKETS);
    end else if (cfg_valid && cfg_ready) begin
      bucket_count <= cfg_data;
    end
  end

  assign busy = front_busy || clearing;

  mcht_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !clearing),
    .busy        (front_busy),
    .opcode      (opcode),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_level  (cell_level),
    .cell_handle (cell_handle),
    .bucket_count(bucket_count),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  mcht_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mcht_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .done        (done),
    .status      (status),
    .found       (found),
    .found_handle(found_handle),
    .entry_count (entry_count)
  );

endmodule

>>> dv/mcht_checker.sv
// mesh cell hash table checker: watches command, config and result channels,
// predicts each result and compares it field by field; uses mcht_pkg
module mcht_checker
  import mcht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         opcode,
  input  logic [8:0]         cell_x,
  input  logic [8:0]         cell_y,
  input  logic [2:0]         cell_level,
  input  logic [15:0]        cell_handle,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [BC_W-1:0]    cfg_data,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic               found,
  input  logic [15:0]        found_handle,
  input  logic [COUNT_W-1:0] entry_count,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [15:0]        handle;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  slot_t              table_slots [BUCKETS][DEPTH];
  int                 table_fill [BUCKETS];
  logic [COUNT_W-1:0] stored_total;
  logic [BC_W-1:0]    bc_reg;
  outcome_t           outcome_q [$];

  assign pending = outcome_q.size();

  function automatic int side_of(input int lv);
    return 32 << lv;
  endfunction

  // bucket index with the clamped bucket count
  function automatic int hash_bucket(input int x, input int y, input int lv);
    int bc;
    int key;
    bc = (bc_reg == 0) ? 1 : ((bc_reg > BUCKETS) ? BUCKETS : int'(bc_reg));
    key = x + y * side_of(lv);
    for (int i = 0; i < lv; i++) key += (side_of(i) * side_of(i)) % bc;
    return key % bc;
  endfunction

  // apply one command to the shadow table and return its outcome
  function automatic outcome_t apply_cmd(input logic [1:0] op, input int x, input int y,
                                         input int lv, input logic [15:0] h);
    outcome_t o;
    int b;
    int k;
    o = '0;
    if (op != OP_NONE) begin
      if (lv > MAX_LEVEL) begin
        o.status = ST_BAD_LEVEL;
      end else begin
        b = hash_bucket(x, y, lv);
        if (op == OP_INSERT) begin
          if (table_fill[b] >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            table_slots[b][table_fill[b]] = '{x: 9'(x), y: 9'(y), level: 3'(lv),
                                              handle: HANDLE_BITS'(h)};
            table_fill[b]++;
            stored_total++;
          end
        end else begin
          k = -1;
          for (int i = 0; i < table_fill[b]; i++)
            if (k < 0 && table_slots[b][i].x == x && table_slots[b][i].y == y &&
                table_slots[b][i].level == lv) k = i;
          if (k < 0) begin
            o.status = ST_NOT_FOUND;
          end else begin
            o.found = 1'b1;
            o.handle = 16'(table_slots[b][k].handle);
            if (op == OP_REMOVE) begin
              for (int i = k; i + 1 < table_fill[b]; i++)
                table_slots[b][i] = table_slots[b][i + 1];
              table_fill[b]--;
              stored_total--;
            end
          end
        end
      end
    end
    o.count = stored_total;
    return o;
  endfunction

  // track transactions on every channel
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) table_fill[i] = 0;
      stored_total = '0;
      bc_reg = BC_W'(1024);
      outcome_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        got = '{status: status, found: found, handle: found_handle, count: entry_count};
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected st=%0d f=%0d h=%h n=%0d got st=%0d f=%0d h=%h n=%0d",
                       want.status, want.found, want.handle, want.count,
                       got.status, got.found, got.handle, got.count);
          end
        end
      end
      if (start && !busy)
        outcome_q = {outcome_q, apply_cmd(opcode, cell_x, cell_y, cell_level, cell_handle)};
      if (cfg_valid && cfg_ready) bc_reg = cfg_data;
    end
  end

endmodule

>>> dv/tb.sv
// mesh cell hash table testbench top: clock, reset, command and config stimulus,
// verdict; uses mcht_pkg, mesh_cell_hash_table_core and mcht_checker
module tb;
  import mcht_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = '0;
  logic [8:0]         cell_x = '0;
  logic [8:0]         cell_y = '0;
  logic [2:0]         cell_level = '0;
  logic [15:0]        cell_handle = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [BC_W-1:0]    cfg_data = '0;
  logic               done;
  logic [1:0]         status;
  logic               found;
  logic [15:0]        found_handle;
  logic [COUNT_W-1:0] entry_count;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  int                 gap_pct = 0;
  logic [8:0]         key_x [$];
  logic [8:0]         key_y [$];
  logic [2:0]         key_lv [$];

  always #4 clk = ~clk;

  mesh_cell_hash_table_core DUT (.*);

  mcht_checker chk (.*);

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb failed");
      $finish;
    end
  end

  // one command transaction, with a random gap ahead of it
  task automatic send_cmd(input logic [1:0] op, input logic [8:0] x, input logic [8:0] y,
                          input logic [2:0] lv, input logic [15:0] h);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1'b1;
    opcode <= op;
    cell_x <= x;
    cell_y <= y;
    cell_level <= lv;
    cell_handle <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    // busy is high for the cycle after an accept, so no slot is lost here
    @(posedge clk);
  endtask

  // write the bucket count once every result is back
  task automatic set_buckets(input logic [BC_W-1:0] bc);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= bc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly operations on keys already inserted, some fresh keys and noise
  task automatic random_cmd();
    logic [1:0] op;
    logic [8:0] x;
    logic [8:0] y;
    logic [2:0] lv;
    int k;
    x = 9'($urandom);
    y = 9'($urandom);
    lv = 3'($urandom_range(4));
    op = 2'($urandom_range(2));
    if ($urandom_range(99) < 8) lv = 3'($urandom_range(7));
    if ($urandom_range(99) < 4) op = OP_NONE;
    if (key_x.size() > 0 && op != OP_INSERT && $urandom_range(99) < 80) begin
      k = $urandom_range(key_x.size() - 1);
      x = key_x[k];
      y = key_y[k];
      lv = key_lv[k];
    end else if (op == OP_INSERT && key_x.size() > 0 && $urandom_range(99) < 30) begin
      k = $urandom_range(key_x.size() - 1);
      x = key_x[k];
      y = key_y[k];
      lv = key_lv[k];
    end
    if (op == OP_INSERT && lv <= MAX_LEVEL) begin
      key_x = {key_x, x};
      key_y = {key_y, y};
      key_lv = {key_lv, lv};
      if (key_x.size() > 64) begin
        void'(key_x.pop_front());
        void'(key_y.pop_front());
        void'(key_lv.pop_front());
      end
    end
    send_cmd(op, x, y, lv, 16'($urandom));
  endtask

  initial begin
    logic [BC_W-1:0] bc_list [8];
    bc_list = '{BC_W'(1), BC_W'(0), BC_W'(2047), BC_W'(3), BC_W'(1024), BC_W'(17),
                BC_W'(1025), BC_W'(256)};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, every opcode, full bucket, duplicates, bad level
    set_buckets(BC_W'(1024));
    send_cmd(OP_SEARCH, 9'd0, 9'd0, 3'd0, 16'h0);
    send_cmd(OP_INSERT, 9'd511, 9'd511, 3'd4, 16'hFFFF);
    send_cmd(OP_SEARCH, 9'd511, 9'd511, 3'd4, 16'h0);
    send_cmd(OP_INSERT, 9'd0, 9'd0, 3'd7, 16'h1234);
    send_cmd(OP_NONE, 9'd5, 9'd5, 3'd1, 16'h5555);
    set_buckets(BC_W'(1));
    for (int i = 0; i < 6; i++) send_cmd(OP_INSERT, 9'(i % 2), 9'd0, 3'd0, 16'(i + 1));
    send_cmd(OP_REMOVE, 9'd1, 9'd0, 3'd0, 16'h0);
    send_cmd(OP_SEARCH, 9'd1, 9'd0, 3'd0, 16'h0);
    send_cmd(OP_REMOVE, 9'd0, 9'd0, 3'd0, 16'h0);
    send_cmd(OP_REMOVE, 9'd7, 9'd7, 3'd5, 16'h0);
    send_cmd(OP_REMOVE, 9'd9, 9'd9, 3'd2, 16'h0);
    send_cmd(OP_SEARCH, 9'd511, 9'd511, 3'd4, 16'hFFFF);
    set_buckets(BC_W'(0));
    send_cmd(OP_REMOVE, 9'd511, 9'd511, 3'd4, 16'h0);
    send_cmd(OP_INSERT, 9'd3, 9'd2, 3'd3, 16'hA5A5);
    // random phases over bucket counts and idling rates
    for (int p = 0; p < 8; p++) begin
      set_buckets(bc_list[p]);
      case (p % 4)
        0: gap_pct = 0;
        1: gap_pct = 54;
        2: gap_pct = 0;
        default: gap_pct = 19;
      endcase
      for (int i = 0; i < 205; i++) random_cmd();
    end
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
